// ===== sv/ile_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed list engine package
// Shared widths, operation and status codes, and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package ile_pkg;

  // Storage geometry.
  localparam int CAPACITY   = 64;
  localparam int DATA_WIDTH = 32;
  localparam int ADDR_W     = 6;
  localparam int CNT_W      = 7;

  localparam logic [CNT_W-1:0] CAP_CNT = 7'(CAPACITY);

  // Operation codes carried by an input item.
  typedef enum logic [2:0] {
    OP_PUSH_HEAD = 3'd0,
    OP_PUSH_TAIL = 3'd1,
    OP_INSERT    = 3'd2,
    OP_EXTRACT   = 3'd3,
    OP_SWAP      = 3'd4,
    OP_POP_HEAD  = 3'd5,
    OP_POP_TAIL  = 3'd6
  } op_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_BAD_INDEX = 2'd3
  } status_t;

  // Kind of storage work an accepted item needs.
  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_INS,
    ACT_REM,
    ACT_SWAP
  } act_t;

  // Controller states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_SHUP,
    S_WR_WORD,
    S_TAKE,
    S_SHDN,
    S_SW_RDB,
    S_SW_WA,
    S_SW_WB,
    S_RESULT
  } state_t;

  // Datapath step requested by the controller.
  typedef enum logic [3:0] {
    CMD_IDLE,
    CMD_DECIDE,
    CMD_SHUP,
    CMD_WR_WORD,
    CMD_TAKE,
    CMD_SHDN,
    CMD_SW_RDB,
    CMD_SW_WA,
    CMD_SW_WB,
    CMD_RESULT
  } step_t;

  typedef struct packed {
    logic  load;
    step_t step;
  } ctrl_cmd_t;

  typedef struct packed {
    act_t act;
    logic shup_done;
    logic shdn_done;
    logic out_free;
  } dp_status_t;

endpackage

// ===== sv/ile_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed list engine controller
// Sequences one item at a time through decode, shifting or swapping, and
// the hand-off of its result to the output register.
// ----------------------------------------------------------------------------
module ile_ctrl import ile_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t dp_status,
  output ctrl_cmd_t  cmd
);

  state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        case (dp_status.act)
          ACT_INS:  state_nxt = S_SHUP;
          ACT_REM:  state_nxt = S_TAKE;
          ACT_SWAP: state_nxt = S_SW_RDB;
          default:  state_nxt = S_RESULT;
        endcase
      end
      S_SHUP: begin
        if (dp_status.shup_done) state_nxt = S_WR_WORD;
      end
      S_WR_WORD: state_nxt = S_RESULT;
      S_TAKE:    state_nxt = S_SHDN;
      S_SHDN: begin
        if (dp_status.shdn_done) state_nxt = S_RESULT;
      end
      S_SW_RDB: state_nxt = S_SW_WA;
      S_SW_WA:  state_nxt = S_SW_WB;
      S_SW_WB:  state_nxt = S_RESULT;
      S_RESULT: begin
        if (dp_status.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    in_ready = 1'b0;
    cmd.load = 1'b0;
    cmd.step = CMD_IDLE;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_DECIDE:  cmd.step = CMD_DECIDE;
      S_SHUP:    cmd.step = CMD_SHUP;
      S_WR_WORD: cmd.step = CMD_WR_WORD;
      S_TAKE:    cmd.step = CMD_TAKE;
      S_SHDN:    cmd.step = CMD_SHDN;
      S_SW_RDB:  cmd.step = CMD_SW_RDB;
      S_SW_WA:   cmd.step = CMD_SW_WA;
      S_SW_WB:   cmd.step = CMD_SW_WB;
      S_RESULT:  cmd.step = CMD_RESULT;
      default:   cmd.step = CMD_IDLE;
    endcase
  end

endmodule

// ===== sv/ile_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed list engine datapath
// Holds the entry memory, the count, the captured item and the result
// register, and carries out the step that the controller requests.
// ----------------------------------------------------------------------------
module ile_datapath import ile_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  ctrl_cmd_t               cmd,
  output dp_status_t              dp_status,
  input  logic [2:0]              in_operation,
  input  logic signed [31:0]      in_element_value,
  input  logic [CNT_W-1:0]        in_position_a,
  input  logic [ADDR_W-1:0]       in_position_b,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [31:0]      out_removed_value,
  output logic [1:0]              out_status,
  output logic [CNT_W-1:0]        out_entry_count
);

  // Entry storage, one write and one registered read per cycle.
  logic [DATA_WIDTH-1:0] mem [CAPACITY];
  logic [DATA_WIDTH-1:0] rd_data_r;
  logic                  rd_en, wr_en;
  logic [ADDR_W-1:0]     rd_addr, wr_addr;
  logic [DATA_WIDTH-1:0] wr_data;

  // Captured item and working registers.
  op_t                   op_r;
  logic [DATA_WIDTH-1:0] word_r;
  logic [CNT_W-1:0]      pa_r;
  logic [ADDR_W-1:0]     pb_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [CNT_W-1:0]      idx_r;
  logic [CNT_W-1:0]      pos_r;
  logic                  pend_r;
  logic [DATA_WIDTH-1:0] tmp_r;
  logic [DATA_WIDTH-1:0] rem_r;
  status_t               status_r;

  // Result register.
  logic                  out_valid_r;
  logic [31:0]           out_removed_r;
  status_t               out_status_r;
  logic [CNT_W-1:0]      out_count_r;

  // Decode results.
  act_t                  act_calc;
  status_t               st_calc;
  logic [CNT_W-1:0]      pos_calc;
  logic                  full, empty;
  logic [CNT_W-1:0]      idx_inc, idx_dec, idx_dec2;
  logic                  more_rd;
  logic                  result_load;

  assign full     = (cnt_r == CAP_CNT);
  assign empty    = (cnt_r == '0);
  assign idx_inc  = idx_r + 7'd1;
  assign idx_dec  = idx_r - 7'd1;
  assign idx_dec2 = idx_r - 7'd2;
  assign more_rd  = (idx_r < cnt_r);

  // Decide the outcome and the position for the captured item.
  always_comb begin
    act_calc = ACT_NONE;
    st_calc  = ST_OK;
    pos_calc = '0;
    case (op_r)
      OP_PUSH_HEAD: begin
        if (full) st_calc = ST_FULL;
        else act_calc = ACT_INS;
      end
      OP_PUSH_TAIL: begin
        pos_calc = cnt_r;
        if (full) st_calc = ST_FULL;
        else act_calc = ACT_INS;
      end
      OP_INSERT: begin
        pos_calc = pa_r;
        if (pa_r > cnt_r) st_calc = ST_BAD_INDEX;
        else if (full) st_calc = ST_FULL;
        else act_calc = ACT_INS;
      end
      OP_EXTRACT: begin
        pos_calc = pa_r;
        if (empty) st_calc = ST_EMPTY;
        else if (pa_r >= cnt_r) st_calc = ST_BAD_INDEX;
        else act_calc = ACT_REM;
      end
      OP_SWAP: begin
        pos_calc = pa_r;
        if (pa_r >= cnt_r || {1'b0, pb_r} >= cnt_r) st_calc = ST_BAD_INDEX;
        else act_calc = ACT_SWAP;
      end
      OP_POP_HEAD: begin
        if (empty) st_calc = ST_EMPTY;
        else act_calc = ACT_REM;
      end
      OP_POP_TAIL: begin
        pos_calc = cnt_r - 7'd1;
        if (empty) st_calc = ST_EMPTY;
        else act_calc = ACT_REM;
      end
      default: st_calc = ST_BAD_INDEX;
    endcase
  end

  // Status back to the controller.
  assign result_load         = (cmd.step == CMD_RESULT) && dp_status.out_free;
  assign dp_status.act       = act_calc;
  assign dp_status.shup_done = (idx_r == pos_r);
  assign dp_status.shdn_done = !pend_r && !more_rd;
  assign dp_status.out_free  = !out_valid_r || out_ready;

  // Memory port selection for each step.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = rd_data_r;
    case (cmd.step)
      CMD_DECIDE: begin
        // Removal reads its first entry now; swap reads its first position.
        rd_en   = (act_calc == ACT_REM) || (act_calc == ACT_SWAP);
        rd_addr = pos_calc[ADDR_W-1:0];
      end
      CMD_SHUP: begin
        // Write the word read last cycle one place up, read the next lower.
        wr_en   = pend_r;
        wr_addr = idx_inc[ADDR_W-1:0];
        rd_en   = !dp_status.shup_done;
        rd_addr = idx_dec[ADDR_W-1:0];
      end
      CMD_WR_WORD: begin
        wr_en   = 1'b1;
        wr_addr = pos_r[ADDR_W-1:0];
        wr_data = word_r;
      end
      CMD_TAKE, CMD_SHDN: begin
        // Write the word read last cycle one place down, read the next higher.
        wr_en   = pend_r;
        wr_addr = idx_dec2[ADDR_W-1:0];
        rd_en   = more_rd;
        rd_addr = idx_r[ADDR_W-1:0];
      end
      CMD_SW_RDB: begin
        rd_en   = 1'b1;
        rd_addr = pb_r;
      end
      CMD_SW_WA: begin
        wr_en   = 1'b1;
        wr_addr = pa_r[ADDR_W-1:0];
      end
      CMD_SW_WB: begin
        wr_en   = 1'b1;
        wr_addr = pb_r;
        wr_data = tmp_r;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  // Entry memory.
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  // Control state: count, pending write flag and result valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      case (cmd.step)
        CMD_DECIDE:  pend_r <= 1'b0;
        CMD_SHUP:    pend_r <= !dp_status.shup_done;
        CMD_WR_WORD: cnt_r  <= cnt_r + 7'd1;
        CMD_TAKE:    pend_r <= more_rd;
        CMD_SHDN: begin
          pend_r <= more_rd;
          if (dp_status.shdn_done) cnt_r <= cnt_r - 7'd1;
        end
        default: pend_r <= pend_r;
      endcase
      if (result_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // Item capture and working payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= op_t'(in_operation);
      word_r <= in_element_value[DATA_WIDTH-1:0];
      pa_r   <= in_position_a;
      pb_r   <= in_position_b;
    end
    case (cmd.step)
      CMD_DECIDE: begin
        pos_r    <= pos_calc;
        status_r <= st_calc;
        rem_r    <= '0;
        if (act_calc == ACT_INS) idx_r <= cnt_r;
        else idx_r <= pos_calc + 7'd1;
      end
      CMD_SHUP: begin
        if (!dp_status.shup_done) idx_r <= idx_dec;
      end
      CMD_TAKE: begin
        rem_r <= rd_data_r;
        if (more_rd) idx_r <= idx_inc;
      end
      CMD_SHDN: begin
        if (more_rd) idx_r <= idx_inc;
      end
      CMD_SW_RDB: tmp_r <= rd_data_r;
      default: tmp_r <= tmp_r;
    endcase
    if (result_load) begin
      out_removed_r <= rem_r;
      out_status_r  <= status_r;
      out_count_r   <= cnt_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_removed_value = out_removed_r;
  assign out_status        = out_status_r;
  assign out_entry_count   = out_count_r;

endmodule

// ===== sv/indexed_list_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed list engine
// Bounded ordered list of signed words with push, pop, insert, extract and
// swap, one result per item.
// ----------------------------------------------------------------------------
// The block takes one item at a time and returns one result for it. The
// entries sit in a single-port-write, registered-read memory, so insert and
// extract move one entry per cycle: an insert or push at position p with n
// entries held moves the n - p entries at and above p one place up, and an
// extract or pop moves those above p one place down. An item waits in its
// result step while the previous result still sits unaccepted in the output
// register. A finished result waits in the output register while the next
// item is already taken in.
// ----------------------------------------------------------------------------
module indexed_list_engine import ile_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          in_operation,
  input  logic signed [31:0]  in_element_value,
  input  logic [CNT_W-1:0]    in_position_a,
  input  logic [ADDR_W-1:0]   in_position_b,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [31:0]  out_removed_value,
  output logic [1:0]          out_status,
  output logic [CNT_W-1:0]    out_entry_count
);

  ctrl_cmd_t  cmd;
  dp_status_t dp_status;

  // Sequencer.
  ile_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .dp_status (dp_status),
    .cmd       (cmd)
  );

  // Storage and result path.
  ile_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .dp_status         (dp_status),
    .in_operation      (in_operation),
    .in_element_value  (in_element_value),
    .in_position_a     (in_position_a),
    .in_position_b     (in_position_b),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_removed_value (out_removed_value),
    .out_status        (out_status),
    .out_entry_count   (out_entry_count)
  );

endmodule

// ===== sv/ile_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed list engine checker
// Port-level properties of the engine, attached to the top level by bind.
// ----------------------------------------------------------------------------
module ile_checker import ile_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic signed [31:0]  out_removed_value,
  input logic [1:0]          out_status,
  input logic [CNT_W-1:0]    out_entry_count
);

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_removed_value)
      && $stable(out_status) && $stable(out_entry_count))
    else $error("result changed while stalled");

  // Only one item is in work at a time.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is in work");

  // A full status only comes with a full list.
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_FULL |-> out_entry_count == CAP_CNT)
    else $error("full status with list not full");

  // An empty refusal returns zero and an empty count.
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_EMPTY |-> out_removed_value == 32'sd0
      && out_entry_count == '0)
    else $error("empty status with data or count");

  // Reset clears the result channel.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind indexed_list_engine ile_checker u_ile_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_removed_value (out_removed_value),
  .out_status        (out_status),
  .out_entry_count   (out_entry_count)
);

// ===== dv/list_result_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// List result checker
// Watches both channels of the indexed list engine, keeps a shadow copy of
// the list, works out the result of every item taken in and compares each
// result that leaves the block against the oldest one still waiting.
// ----------------------------------------------------------------------------
module list_result_checker import ile_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic [2:0]          in_operation,
  input  logic signed [31:0]  in_element_value,
  input  logic [CNT_W-1:0]    in_position_a,
  input  logic [ADDR_W-1:0]   in_position_b,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic signed [31:0]  out_removed_value,
  input  logic [1:0]          out_status,
  input  logic [CNT_W-1:0]    out_entry_count,
  output int                  mismatch_count,
  output int                  results_pending,
  output int                  list_depth
);

  typedef struct packed {
    logic signed [31:0] removed;
    status_t            status;
    logic [CNT_W-1:0]   count;
  } list_result_t;

  // Shadow list: position 0 is the head, shadow_len - 1 the tail.
  logic signed [DATA_WIDTH-1:0] shadow_words [CAPACITY];
  int                           shadow_len;
  list_result_t                 awaited_results [$];

  assign list_depth = shadow_len;

  // Opens a gap at pos and stores the word there, unless the list is full.
  function automatic status_t place_word(int pos, logic signed [DATA_WIDTH-1:0] w);
    if (shadow_len >= CAPACITY) return ST_FULL;
    for (int i = shadow_len; i > pos; i--) shadow_words[i] = shadow_words[i-1];
    shadow_words[pos] = w;
    shadow_len++;
    return ST_OK;
  endfunction

  // Removes the word at pos, closes the gap and returns it sign-extended.
  function automatic logic signed [31:0] take_word(int pos);
    logic signed [DATA_WIDTH-1:0] w;
    w = shadow_words[pos];
    for (int i = pos; i < shadow_len - 1; i++) shadow_words[i] = shadow_words[i+1];
    shadow_len--;
    return 32'(w);
  endfunction

  // Applies one operation to the shadow list and returns its result.
  function automatic list_result_t apply_list_op(logic [2:0] op, logic signed [31:0] value,
                                                 int pa, int pb);
    list_result_t                 r;
    logic signed [DATA_WIDTH-1:0] w;
    logic signed [DATA_WIDTH-1:0] t;
    r.removed = '0;
    r.status  = ST_OK;
    w = DATA_WIDTH'(value);
    case (op)
      OP_PUSH_HEAD: r.status = place_word(0, w);
      OP_PUSH_TAIL: r.status = place_word(shadow_len, w);
      OP_INSERT: begin
        if (pa > shadow_len) r.status = ST_BAD_INDEX;
        else r.status = place_word(pa, w);
      end
      OP_EXTRACT: begin
        if (shadow_len == 0) r.status = ST_EMPTY;
        else if (pa >= shadow_len) r.status = ST_BAD_INDEX;
        else r.removed = take_word(pa);
      end
      OP_SWAP: begin
        if (pa >= shadow_len || pb >= shadow_len) begin
          r.status = ST_BAD_INDEX;
        end else begin
          t = shadow_words[pa];
          shadow_words[pa] = shadow_words[pb];
          shadow_words[pb] = t;
        end
      end
      OP_POP_HEAD: begin
        if (shadow_len == 0) r.status = ST_EMPTY;
        else r.removed = take_word(0);
      end
      OP_POP_TAIL: begin
        if (shadow_len == 0) r.status = ST_EMPTY;
        else r.removed = take_word(shadow_len - 1);
      end
      default: r.status = ST_BAD_INDEX;
    endcase
    r.count = CNT_W'(shadow_len);
    return r;
  endfunction

  // Results are compared before the item of the same edge is predicted, since
  // a result can never leave on the edge at which its own item arrives.
  always @(posedge clk) begin : monitor
    list_result_t want;
    if (!rst_n) begin
      shadow_len = 0;
      awaited_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: result with nothing awaited: removed %0d status %0d count %0d",
                   $time, out_removed_value, out_status, out_entry_count);
          mismatch_count++;
        end else begin
          want = awaited_results.pop_front();
          if (out_removed_value !== want.removed) begin
            $display("%0t: removed_value expected %0d actual %0d",
                     $time, want.removed, out_removed_value);
            mismatch_count++;
          end
          if (out_status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, out_status);
            mismatch_count++;
          end
          if (out_entry_count !== want.count) begin
            $display("%0t: entry_count expected %0d actual %0d",
                     $time, want.count, out_entry_count);
            mismatch_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        awaited_results.push_back(apply_list_op(in_operation, in_element_value,
                                                int'(in_position_a), int'(in_position_b)));
      end
    end
    results_pending = awaited_results.size();
  end

endmodule

// ===== dv/tb_indexed_list_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed list engine testbench
// Drives directed corner items, then rounds that fill the list to capacity,
// mix operations and drain it again, under changing idle patterns on both
// channels and one long output hold-off. A separate checker predicts and
// compares every result; this top gives the verdict.
// ----------------------------------------------------------------------------
module tb_indexed_list_engine import ile_pkg::*;;

  localparam logic [2:0] OP_UNUSED = 3'd7;

  localparam int TARGET_ITEMS = 1150;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int HOLD_OFF_AT  = 950;
  localparam int HOLD_OFF_LEN = 400;
  localparam int SETTLE_TIME  = 100;

  typedef enum {MODE_FILL, MODE_MIX, MODE_DRAIN} traffic_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [2:0]         in_operation;
  logic signed [31:0] in_element_value;
  logic [CNT_W-1:0]   in_position_a;
  logic [ADDR_W-1:0]  in_position_b;
  logic               out_valid;
  logic               out_ready;
  logic signed [31:0] out_removed_value;
  logic [1:0]         out_status;
  logic [CNT_W-1:0]   out_entry_count;

  int mismatch_count;
  int results_pending;
  int list_depth;
  int items_sent    = 0;
  int send_idle_pct = 17;
  int recv_idle_pct = 84;
  int cycle_count   = 0;
  bit hold_off_done = 1'b0;

  indexed_list_engine uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_operation      (in_operation),
    .in_element_value  (in_element_value),
    .in_position_a     (in_position_a),
    .in_position_b     (in_position_b),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_removed_value (out_removed_value),
    .out_status        (out_status),
    .out_entry_count   (out_entry_count)
  );

  list_result_checker checker_i (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_operation      (in_operation),
    .in_element_value  (in_element_value),
    .in_position_a     (in_position_a),
    .in_position_b     (in_position_b),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_removed_value (out_removed_value),
    .out_status        (out_status),
    .out_entry_count   (out_entry_count),
    .mismatch_count    (mismatch_count),
    .results_pending   (results_pending),
    .list_depth        (list_depth)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // Result side: random stalls, plus one long hold-off while items keep coming.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_off_done && items_sent >= HOLD_OFF_AT) begin
        hold_off_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_LEN - 1) @(negedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Mostly random words, with the extremes and all-zero/all-one often.
  function automatic logic signed [31:0] pick_word();
    case ($urandom_range(7))
      0:       return 32'sh7fffffff;
      1:       return 32'sh80000000;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Offers one item and returns at the falling edge after its transfer.
  task automatic offer(input logic [2:0] op, input logic signed [31:0] value,
                       input int pa, input int pb);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_operation     <= op;
    in_element_value <= value;
    in_position_a    <= CNT_W'(pa);
    in_position_b    <= ADDR_W'(pb);
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    // Idle pattern follows the progress of the run.
    if (items_sent >= 800) begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end else if (items_sent >= 400) begin
      send_idle_pct = 84;
      recv_idle_pct = 17;
    end
    @(negedge clk);
  endtask

  // One random item, leaning toward growth, shrinkage or a plain mix.
  task automatic random_item(input traffic_t mode);
    logic [2:0] grow_ops [3];
    logic [2:0] shrink_ops [3];
    logic [2:0] op;
    int         depth;
    int         pa;
    int         pb;
    int         roll;
    // Nothing more is sent once the item budget is spent.
    if (items_sent >= TARGET_ITEMS) return;
    grow_ops   = '{OP_PUSH_HEAD, OP_PUSH_TAIL, OP_INSERT};
    shrink_ops = '{OP_POP_HEAD, OP_POP_TAIL, OP_EXTRACT};
    depth = list_depth;
    roll  = $urandom_range(99);
    case (mode)
      MODE_FILL:  op = (roll < 90) ? grow_ops[$urandom_range(2)] : 3'($urandom_range(7));
      MODE_DRAIN: op = (roll < 90) ? shrink_ops[$urandom_range(2)] : 3'($urandom_range(7));
      default:    op = (roll < 3) ? OP_UNUSED : 3'($urandom_range(6));
    endcase
    // Positions mostly within the list, sometimes anywhere the field allows.
    if ($urandom_range(99) < 85) pa = $urandom_range(depth, 0);
    else pa = $urandom_range(127);
    if (depth > 0 && $urandom_range(99) < 85) pb = $urandom_range(depth - 1, 0);
    else pb = $urandom_range(63);
    offer(op, pick_word(), pa, pb);
  endtask

  // Stimulus and verdict.
  initial begin
    int mix_len;
    int drain_floor;
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_operation     = OP_PUSH_HEAD;
    in_element_value = '0;
    in_position_a    = '0;
    in_position_b    = '0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: refusals on an empty list, then a small list worked over.
    offer(OP_POP_HEAD, pick_word(), 0, 0);
    offer(OP_POP_TAIL, pick_word(), 0, 0);
    offer(OP_EXTRACT, pick_word(), 0, 0);
    offer(OP_EXTRACT, pick_word(), 127, 0);
    offer(OP_SWAP, pick_word(), 0, 0);
    offer(OP_UNUSED, pick_word(), 0, 0);
    offer(OP_INSERT, pick_word(), 1, 0);
    offer(OP_PUSH_HEAD, 32'sh7fffffff, 0, 0);
    offer(OP_PUSH_TAIL, 32'sh80000000, 0, 0);
    offer(OP_INSERT, -32'sd1, 1, 0);
    offer(OP_INSERT, 32'sd0, 0, 0);
    offer(OP_INSERT, 32'sh5a5a5a5a, 4, 0);
    offer(OP_INSERT, pick_word(), 6, 0);
    offer(OP_SWAP, pick_word(), 0, 4);
    offer(OP_SWAP, pick_word(), 2, 2);
    offer(OP_SWAP, pick_word(), 5, 0);
    offer(OP_SWAP, pick_word(), 0, 63);
    offer(OP_EXTRACT, pick_word(), 5, 0);
    offer(OP_EXTRACT, pick_word(), 127, 0);
    offer(OP_EXTRACT, pick_word(), 4, 0);
    offer(OP_EXTRACT, pick_word(), 1, 0);
    offer(OP_POP_HEAD, pick_word(), 0, 0);
    offer(OP_POP_TAIL, pick_word(), 0, 0);
    offer(OP_UNUSED, pick_word(), 0, 0);
    offer(OP_POP_HEAD, pick_word(), 0, 0);

    // Random rounds: fill to capacity, press against full, mix, drain part
    // way, mix again, then drain to empty and press against empty.
    while (items_sent < TARGET_ITEMS) begin
      while (items_sent < TARGET_ITEMS && list_depth < CAPACITY) random_item(MODE_FILL);
      repeat (4) random_item(MODE_FILL);
      mix_len = $urandom_range(60, 20);
      repeat (mix_len) random_item(MODE_MIX);
      drain_floor = $urandom_range(40);
      while (items_sent < TARGET_ITEMS && list_depth > drain_floor) random_item(MODE_DRAIN);
      mix_len = $urandom_range(40, 10);
      repeat (mix_len) random_item(MODE_MIX);
      while (items_sent < TARGET_ITEMS && list_depth > 0) random_item(MODE_DRAIN);
      repeat (3) random_item(MODE_DRAIN);
    end
    in_valid <= 1'b0;

    // Wait out the last results, then a little longer for strays.
    while (results_pending != 0) @(negedge clk);
    repeat (SETTLE_TIME) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== indexed_list_engine.f =====
sv/ile_pkg.sv
sv/ile_ctrl.sv
sv/ile_datapath.sv
sv/indexed_list_engine.sv
sv/ile_checker.sv
dv/list_result_checker.sv
dv/tb_indexed_list_engine.sv
